/* rtl/fpmu_pkg.sv */
// shared types and constants for the 16.16 fixed-point math unit
// no dependencies
package fpmu_pkg;

  // operation codes
  localparam logic [2:0] OP_RMUL   = 3'd0;
  localparam logic [2:0] OP_MSHIFT = 3'd1;
  localparam logic [2:0] OP_DIV    = 3'd2;
  localparam logic [2:0] OP_SCALE  = 3'd3;
  localparam logic [2:0] OP_SQRT   = 3'd4;

  // one quotient bit per stage over the whole 64-bit dividend
  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = 6;

  // square root phase boundaries, counted in stages
  localparam logic [STEP_W-1:0] SQRT_INT_LAST  = 6'd15;
  localparam logic [STEP_W-1:0] SQRT_FRAC_LAST = 6'd23;

  localparam logic [31:0] SQRT_INT_MASK  = 32'h4000_0000;
  localparam logic [31:0] SQRT_FRAC_MASK = 32'h0000_4000;

  // payload carried down the step pipeline
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] num;   // dividend magnitude, shifted out msb first
    logic [31:0] rem;   // partial remainder
    logic [31:0] den;   // divisor magnitude
    logic [31:0] quo;   // low quotient bits
    logic        neg;   // quotient must be negated
    logic        dz;    // zero divisor seen
    logic [31:0] root;  // square root partial root
    logic [31:0] rad;   // square root running value
    logic [31:0] res;   // result of the multiply operations
  } pipe_t;

endpackage

/* rtl/fpmu_prep.sv */
// front end: input register, 32x32 signed multiply, operand preparation
// depends on fpmu_pkg
module fpmu_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [2:0]           in_op,
  input  logic signed [31:0]   in_a,
  input  logic signed [31:0]   in_b,
  input  logic signed [31:0]   in_c,
  input  logic [5:0]           in_sh,
  output logic                 out_vld,
  output fpmu_pkg::pipe_t      out_pl
);

  logic                a_vld_r, b_vld_r, c_vld_r;
  logic [2:0]          a_op_r, b_op_r;
  logic signed [31:0]  a_a_r, a_b_r, a_c_r, b_a_r, b_b_r, b_c_r;
  logic [5:0]          a_sh_r, b_sh_r;
  logic signed [63:0]  prod_r;
  fpmu_pkg::pipe_t     pl_nxt, pl_r;

  logic [63:0] n_sel, prod_rnd, prod_shr;
  logic [31:0] d_sel;
  logic        is_div;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // input register, delayed operands, product register and payload register
  always_ff @(posedge clk) begin
    a_op_r <= in_op;
    a_a_r  <= in_a;
    a_b_r  <= in_b;
    a_c_r  <= in_c;
    a_sh_r <= in_sh;
    b_op_r <= a_op_r;
    b_a_r  <= a_a_r;
    b_b_r  <= a_b_r;
    b_c_r  <= a_c_r;
    b_sh_r <= a_sh_r;
    prod_r <= a_a_r * a_b_r;
    pl_r   <= pl_nxt;
  end

  // dividend and divisor selection, multiply results
  always_comb begin
    is_div   = (b_op_r == fpmu_pkg::OP_DIV);
    n_sel    = is_div ? {{16{b_a_r[31]}}, b_a_r, 16'h0000} : prod_r;
    d_sel    = is_div ? b_b_r : b_c_r;
    prod_rnd = prod_r + 64'h0000_0000_0000_8000;
    prod_shr = prod_r >> b_sh_r;

    pl_nxt      = '0;
    pl_nxt.op   = b_op_r;
    pl_nxt.num  = n_sel[63] ? (64'd0 - n_sel) : n_sel;
    pl_nxt.den  = d_sel[31] ? (32'd0 - d_sel) : d_sel;
    pl_nxt.neg  = n_sel[63] ^ d_sel[31];
    pl_nxt.dz   = (d_sel == 32'd0) &&
                  (is_div || (b_op_r == fpmu_pkg::OP_SCALE));
    pl_nxt.rad  = b_a_r;
    if (b_op_r == fpmu_pkg::OP_RMUL) begin
      pl_nxt.res = prod_rnd[47:16];
    end else if (b_op_r == fpmu_pkg::OP_MSHIFT) begin
      pl_nxt.res = prod_shr[31:0];
    end
  end

  assign out_vld = c_vld_r;
  assign out_pl  = pl_r;

endmodule

/* rtl/fpmu_step.sv */
// one pipeline stage: one restoring divide step and, in early stages,
// one square root digit; depends on fpmu_pkg
module fpmu_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fpmu_pkg::STEP_W-1:0]         step_idx,
  input  logic                                in_vld,
  input  fpmu_pkg::pipe_t                     in_pl,
  output logic                                out_vld,
  output fpmu_pkg::pipe_t                     out_pl
);

  logic            vld_r;
  fpmu_pkg::pipe_t pl_nxt, pl_r;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic [31:0] m_int, m_frac, d1, d2, trial, root_n, rad_n;
  logic        acc;

  always_comb begin
    pl_nxt = in_pl;

    // divide step
    rem_sh     = {in_pl.rem, in_pl.num[63]};
    diff       = {1'b0, rem_sh} - {2'b00, in_pl.den};
    pl_nxt.num = {in_pl.num[62:0], 1'b0};
    if (!diff[33]) begin
      pl_nxt.rem = diff[31:0];
      pl_nxt.quo = {in_pl.quo[30:0], 1'b1};
    end else begin
      pl_nxt.rem = rem_sh[31:0];
      pl_nxt.quo = {in_pl.quo[30:0], 1'b0};
    end

    // square root digit
    m_int  = fpmu_pkg::SQRT_INT_MASK >> {step_idx[3:0], 1'b0};
    m_frac = fpmu_pkg::SQRT_FRAC_MASK >> {step_idx[2:0], 1'b0};
    d1     = in_pl.rad - m_int;
    d2     = d1 - in_pl.root;
    trial  = in_pl.root + m_frac;
    acc    = 1'b0;
    root_n = in_pl.root;
    rad_n  = in_pl.rad;
    if (step_idx <= fpmu_pkg::SQRT_INT_LAST) begin
      // integer phase, sign-bit tests on wrapped differences
      acc    = !d1[31] && !d2[31];
      root_n = acc ? ((in_pl.root >> 1) | m_int) : (in_pl.root >> 1);
      rad_n  = acc ? d2 : in_pl.rad;
      if (step_idx == fpmu_pkg::SQRT_INT_LAST) begin
        root_n = root_n << 16;
        rad_n  = rad_n << 16;
      end
    end else if (step_idx <= fpmu_pkg::SQRT_FRAC_LAST) begin
      // fraction phase, unsigned compare
      if (trial > in_pl.rad) begin
        root_n = in_pl.root >> 1;
      end else begin
        rad_n  = in_pl.rad - trial;
        root_n = (in_pl.root >> 1) | m_frac;
      end
    end
    pl_nxt.root = root_n;
    pl_nxt.rad  = rad_n;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    pl_r <= pl_nxt;
  end

  assign out_vld = vld_r;
  assign out_pl  = pl_r;

endmodule

/* rtl/fixed_point_math_unit.sv */
// top level of the 16.16 fixed-point math unit: front end, step pipeline,
// result select; depends on fpmu_pkg, fpmu_prep, fpmu_step
//
//   channel   handshake         payload
//   input     start / busy      in_req_type in_operand_a/b/c in_shift_amount
//   result    out_valid strobe  out_result_value out_divide_by_zero
//
// one transaction is accepted every cycle; busy is always low
// the path runs through the input register, multiplier, operand prep, 64 divide
// steps (one quotient bit each) and the result register
// the 64-step divider sets the latency; square root finishes in its first 24
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the pipeline never holds
module fixed_point_math_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_operand_a,
  input  logic signed [31:0]  in_operand_b,
  input  logic signed [31:0]  in_operand_c,
  input  logic [5:0]          in_shift_amount,
  output logic                out_valid,
  output logic signed [31:0]  out_result_value,
  output logic                out_divide_by_zero
);

  logic            vld [0:fpmu_pkg::DIV_STEPS];
  fpmu_pkg::pipe_t pl  [0:fpmu_pkg::DIV_STEPS];

  logic            out_valid_r, out_dz_r, dz_nxt;
  logic [31:0]     out_res_r, res_nxt, quo_s;
  fpmu_pkg::pipe_t last;

  assign busy = 1'b0;

  // front end
  fpmu_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_op   (in_req_type),
    .in_a    (in_operand_a),
    .in_b    (in_operand_b),
    .in_c    (in_operand_c),
    .in_sh   (in_shift_amount),
    .out_vld (vld[0]),
    .out_pl  (pl[0])
  );

  // divide and square root steps
  for (genvar k = 0; k < fpmu_pkg::DIV_STEPS; k++) begin : g_step
    fpmu_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (fpmu_pkg::STEP_W'(k)),
      .in_vld   (vld[k]),
      .in_pl    (pl[k]),
      .out_vld  (vld[k+1]),
      .out_pl   (pl[k+1])
    );
  end

  // result select
  always_comb begin
    last    = pl[fpmu_pkg::DIV_STEPS];
    quo_s   = last.neg ? (32'd0 - last.quo) : last.quo;
    dz_nxt  = last.dz;
    res_nxt = last.res;
    if (last.op == fpmu_pkg::OP_DIV || last.op == fpmu_pkg::OP_SCALE) begin
      res_nxt = last.dz ? 32'd0 : quo_s;
    end else if (last.op == fpmu_pkg::OP_SQRT) begin
      res_nxt = last.root;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[fpmu_pkg::DIV_STEPS];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_res_r <= res_nxt;
    out_dz_r  <= dz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_res_r;
  assign out_divide_by_zero = out_dz_r;

`ifndef SYNTHESIS
  // zero divisor always yields a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == 32'd0)
    else $error("zero divisor with nonzero result");

  // flag only comes from divide or scale
  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |->
      ($past(last.op) == fpmu_pkg::OP_DIV || $past(last.op) == fpmu_pkg::OP_SCALE))
    else $error("divide by zero flag on wrong operation");

  // strobe follows the last pipeline stage
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    vld[fpmu_pkg::DIV_STEPS] |=> out_valid)
    else $error("result strobe lost");
`endif

endmodule

/* bench/fixed_point_math_unit_tb.sv */
// self-checking testbench for the 16.16 fixed-point math unit
// holds its own arithmetic predictor and a scoreboard class; depends on fpmu_pkg and fixed_point_math_unit
`timescale 1ns / 1ps

module fixed_point_math_unit_tb;

  typedef struct {
    logic [31:0] value;
    logic        dz;
  } math_result_t;

  int error_count = 0;

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // digit-by-digit square root on the raw 32-bit pattern
  function automatic logic [31:0] calc_root(input logic [31:0] n);
    logic [31:0] root, mask, val, d, trial;
    root = 0;
    mask = fpmu_pkg::SQRT_INT_MASK;
    val = n;
    while (mask != 0) begin
      d = val - mask;
      if (!d[31]) begin
        d = d - root;
        if (!d[31]) begin
          val = d;
          root = (root >> 1) | mask;
          mask = mask >> 2;
          continue;
        end
      end
      root = root >> 1;
      mask = mask >> 2;
    end
    mask = fpmu_pkg::SQRT_FRAC_MASK;
    root = root << 16;
    val = val << 16;
    while (mask != 0) begin
      trial = root + mask;
      if (trial > val) begin
        root = root >> 1;
      end else begin
        val = val - trial;
        root = (root >> 1) | mask;
      end
      mask = mask >> 2;
    end
    return root;
  endfunction

  // expected result of one request
  function automatic math_result_t calc_math(input logic [2:0] op,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] c, input logic [5:0] sh);
    math_result_t r;
    logic signed [63:0] prod, q;
    logic [63:0] u;
    r.value = 0;
    r.dz = 0;
    prod = 64'(a) * 64'(b);
    case (op)
      fpmu_pkg::OP_RMUL: begin
        u = prod + 64'h8000;
        r.value = u[47:16];
      end
      fpmu_pkg::OP_MSHIFT: begin
        u = 64'(prod) >> sh;
        r.value = u[31:0];
      end
      fpmu_pkg::OP_DIV: begin
        if (b == 0) r.dz = 1;
        else begin
          q = (64'(a) <<< 16) / 64'(b);
          r.value = q[31:0];
        end
      end
      fpmu_pkg::OP_SCALE: begin
        if (c == 0) r.dz = 1;
        else begin
          q = prod / 64'(c);
          r.value = q[31:0];
        end
      end
      fpmu_pkg::OP_SQRT: r.value = calc_root(a);
      default: ;
    endcase
    return r;
  endfunction

  // in-order store of expected results
  class math_scoreboard;
    math_result_t pending[$];
    int checked = 0;

    function void note_request(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic [5:0] sh);
      pending.push_back(calc_math(op, a, b, c, sh));
    endfunction

    task check_result(logic [31:0] value, logic dz);
      math_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", value, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (value !== e.value) report_mismatch("result_value", value, e.value);
      if (dz !== e.dz) report_mismatch("divide_by_zero", dz, e.dz);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_req_type = 0;
  logic signed [31:0] in_operand_a = 0, in_operand_b = 0, in_operand_c = 0;
  logic [5:0] in_shift_amount = 0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic out_divide_by_zero;

  math_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0;

  fixed_point_math_unit dut (.*);

  always #6 clk = ~clk;

  // results and accepted transactions sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_result_value, out_divide_by_zero);
      if (start && !busy)
        sb.note_request(in_req_type, in_operand_a, in_operand_b, in_operand_c,
                        in_shift_amount);
    end
  end

  // present one transaction, after random idle cycles
  task automatic send_req(input logic [2:0] op, input logic [31:0] a,
      input logic [31:0] b, input logic [31:0] c, input logic [5:0] sh);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_req_type <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_c <= c;
    in_shift_amount <= sh;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // operand biased toward edge values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_ffff;
      4: return 32'($signed($urandom_range(600)) - 300);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [31:0] edges[4];
    int k;
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: edges, each operation, zero divisors, unused codes
    for (int i = 0; i < 4; i++) begin
      send_req(fpmu_pkg::OP_RMUL, edges[i], edges[3 - i], 1, 0);
      send_req(fpmu_pkg::OP_SQRT, edges[i], 0, 0, 0);
    end
    send_req(fpmu_pkg::OP_MSHIFT, 32'h8000_0000, 32'h8000_0000, 0, 6'd63);
    send_req(fpmu_pkg::OP_MSHIFT, 32'hffff_ffff, 32'h7fff_ffff, 0, 6'd0);
    send_req(fpmu_pkg::OP_MSHIFT, 32'h1234_5678, 32'hfedc_ba98, 0, 6'd32);
    send_req(fpmu_pkg::OP_DIV, 32'h0003_0000, 0, 0, 0);
    send_req(fpmu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0);
    send_req(fpmu_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001, 0, 0);
    send_req(fpmu_pkg::OP_DIV, 32'hfffd_0000, 32'h0002_0000, 0, 0);
    send_req(fpmu_pkg::OP_SCALE, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_req(fpmu_pkg::OP_SCALE, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0);
    send_req(fpmu_pkg::OP_SCALE, 32'h7fff_ffff, 32'hffff_fffd, 32'h0000_0007, 0);
    send_req(fpmu_pkg::OP_SQRT, 32'h0004_0000, 0, 0, 0);
    send_req(3'd5, 32'h7fff_ffff, 1, 1, 6'd63);
    send_req(3'd6, 32'h1, 1, 1, 0);
    send_req(3'd7, 32'hffff_ffff, 0, 0, 0);
    // random phases: no idling, sender idle, receiver phase (cannot stall), mixed
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 51 : (p == 3) ? 28 : 0;
      for (int i = 0; i < 138; i++) begin
        k = $urandom_range(99);
        send_req(k < 96 ? 3'(k % 5) : 3'($urandom_range(7, 5)), pick_operand(),
                 pick_operand(), pick_operand(), 6'($urandom));
      end
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d requests over all five operations and unused codes,", sent);
    $display("%0d results checked under four idle patterns", sb.checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/fpmu_pkg.sv
rtl/fpmu_prep.sv
rtl/fpmu_step.sv
rtl/fixed_point_math_unit.sv
bench/fixed_point_math_unit_tb.sv
